// File: design/bhpq_pkg.sv
// Package for the binary heap priority queue core.
// Holds sizes, field codes, entry type, controller command and status types, and the key order function.
// No dependencies.
package bhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_START,
        OP_PUSH_READ,
        OP_PUSH_STEP,
        OP_PLACE,
        OP_ROOT_READ,
        OP_ROOT_TAKE,
        OP_SINK_READ,
        OP_SINK_STEP,
        OP_FAIL_EMPTY,
        OP_FAIL_FULL,
        OP_NO_KIND
    } t_op;

    typedef struct packed {
        t_op  op;
        logic pop;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic has_child;
        logic push_move;
        logic sink_move;
        logic out_busy;
    } t_sts;

    function automatic logic serves_after(
        input logic signed [KEY_W-1:0] a,
        input logic signed [KEY_W-1:0] b,
        input logic                    largest
    );
        return largest ? (a < b) : (a > b);
    endfunction

endpackage

// File: design/bhpq_ctrl.sv
// Controller state machine of the binary heap priority queue core.
// Sequences push, pop and peek over the datapath; uses bhpq_pkg.
module bhpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_kind,
    output logic            o_stall,
    input  bhpq_pkg::t_sts  i_sts,
    output bhpq_pkg::t_cmd  o_cmd
);
    import bhpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_PUSH_CHK  = 8'b0000_0010,
        S_PUSH_CMP  = 8'b0000_0100,
        S_ROOT_RD   = 8'b0000_1000,
        S_ROOT_TAKE = 8'b0001_0000,
        S_SINK_CHK  = 8'b0010_0000,
        S_SINK_CMP  = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_pop, n_is_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_pop <= n_is_pop;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_is_pop       = r_is_pop;
        o_cmd.op       = OP_NONE;
        o_cmd.pop      = r_is_pop;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        KIND_PUSH: begin
                            if (i_sts.full) begin
                                o_cmd.op = OP_FAIL_FULL;
                                n_state  = S_DONE;
                            end else begin
                                o_cmd.op = OP_PUSH_START;
                                n_state  = S_PUSH_CHK;
                            end
                        end
                        KIND_POP, KIND_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.op = OP_FAIL_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_is_pop = (i_kind == KIND_POP);
                                n_state  = S_ROOT_RD;
                            end
                        end
                        default: begin
                            o_cmd.op = OP_NO_KIND;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_PUSH_CHK: begin
                if (i_sts.at_root) begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_PUSH_READ;
                    n_state  = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                o_cmd.op = OP_PUSH_STEP;
                n_state  = i_sts.push_move ? S_PUSH_CHK : S_DONE;
            end
            S_ROOT_RD: begin
                o_cmd.op = OP_ROOT_READ;
                n_state  = S_ROOT_TAKE;
            end
            S_ROOT_TAKE: begin
                o_cmd.op = OP_ROOT_TAKE;
                n_state  = r_is_pop ? S_SINK_CHK : S_DONE;
            end
            S_SINK_CHK: begin
                if (i_sts.has_child) begin
                    o_cmd.op = OP_SINK_READ;
                    n_state  = S_SINK_CMP;
                end else begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_DONE;
                end
            end
            S_SINK_CMP: begin
                o_cmd.op = OP_SINK_STEP;
                n_state  = i_sts.sink_move ? S_SINK_CHK : S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/bhpq_dp.sv
// Datapath of the binary heap priority queue core: heap memory, count,
// moving entry, compare logic and the output register. Uses bhpq_pkg.
module bhpq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic signed [bhpq_pkg::KEY_W-1:0] i_in_key,
    input  logic [bhpq_pkg::TAG_W-1:0]    i_in_tag,
    input  bhpq_pkg::t_cmd                i_cmd,
    output bhpq_pkg::t_sts                o_sts,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [bhpq_pkg::KEY_W-1:0] o_out_key,
    output logic [bhpq_pkg::TAG_W-1:0]    o_out_tag,
    output logic                          o_out_valid,
    output logic [bhpq_pkg::CNT_W-1:0]    o_entry_total,
    output logic [1:0]                    o_status
);
    import bhpq_pkg::*;

    t_entry            r_mem [CAPACITY];
    t_entry            r_rd_a, r_rd_b;
    t_entry            r_entry;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic              r_largest;
    t_entry            r_res;
    logic              r_res_valid;
    logic [1:0]        r_res_status;
    logic              r_ovld;

    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    t_entry            wr_data;

    logic [CNT_W:0]    k_x2;
    logic [CNT_W-1:0]  k_m1, k_half_m1, cnt_m1;
    logic [CNT_W:0]    k_x2_m1;
    logic              has_right, pick_right;
    t_entry            child;
    logic [CNT_W:0]    pick_idx;

    assign k_x2      = {r_k, 1'b0};
    assign k_x2_m1   = k_x2 - (CNT_W+1)'(1);
    assign k_m1      = r_k - CNT_W'(1);
    assign k_half_m1 = (r_k >> 1) - CNT_W'(1);
    assign cnt_m1    = r_count - CNT_W'(1);
    assign has_right = k_x2 < {1'b0, r_count};
    assign pick_right = has_right && serves_after(r_rd_a.key, r_rd_b.key, r_largest);
    assign child     = pick_right ? r_rd_b : r_rd_a;
    assign pick_idx  = k_x2 + {{CNT_W{1'b0}}, pick_right};

    assign o_sts.full      = (r_count == CNT_W'(CAPACITY));
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.at_root   = (r_k == CNT_W'(1));
    assign o_sts.has_child = (k_x2 <= {1'b0, r_count});
    assign o_sts.push_move = serves_after(r_rd_a.key, r_entry.key, r_largest);
    assign o_sts.sink_move = serves_after(r_entry.key, child.key, r_largest);
    assign o_sts.out_busy  = r_ovld && i_stall;

    always_comb begin
        mem_we    = 1'b0;
        wr_addr   = k_m1[ADDR_W-1:0];
        wr_data   = r_entry;
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (i_cmd.op)
            OP_PUSH_READ: rd_addr_a = k_half_m1[ADDR_W-1:0];
            OP_PUSH_STEP: begin
                mem_we  = 1'b1;
                wr_data = o_sts.push_move ? r_rd_a : r_entry;
            end
            OP_PLACE:     mem_we = 1'b1;
            OP_ROOT_READ: rd_addr_b = cnt_m1[ADDR_W-1:0];
            OP_SINK_READ: begin
                rd_addr_a = k_x2_m1[ADDR_W-1:0];
                rd_addr_b = k_x2[ADDR_W-1:0];
            end
            OP_SINK_STEP: begin
                mem_we  = 1'b1;
                wr_data = o_sts.sink_move ? child : r_entry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_largest <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_largest <= i_cfg_wdata;
            end
            if (i_cmd.op == OP_PUSH_START) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.op == OP_ROOT_TAKE && i_cmd.pop) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_PUSH_START: begin
                r_entry      <= '{key: i_in_key, tag: i_in_tag};
                r_k          <= r_count + CNT_W'(1);
                r_res        <= '0;
                r_res_valid  <= 1'b0;
                r_res_status <= ST_OK;
            end
            OP_PUSH_STEP: begin
                if (o_sts.push_move) begin
                    r_k <= r_k >> 1;
                end
            end
            OP_ROOT_TAKE: begin
                r_res        <= r_rd_a;
                r_res_valid  <= 1'b1;
                r_res_status <= ST_OK;
                r_entry      <= r_rd_b;
                r_k          <= CNT_W'(1);
            end
            OP_SINK_STEP: begin
                if (o_sts.sink_move) begin
                    r_k <= pick_idx[CNT_W-1:0];
                end
            end
            OP_FAIL_EMPTY: begin
                r_res        <= '0;
                r_res_valid  <= 1'b0;
                r_res_status <= ST_EMPTY;
            end
            OP_FAIL_FULL: begin
                r_res        <= '0;
                r_res_valid  <= 1'b0;
                r_res_status <= ST_FULL;
            end
            OP_NO_KIND: begin
                r_res        <= '0;
                r_res_valid  <= 1'b0;
                r_res_status <= ST_OK;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            o_out_key     <= r_res.key;
            o_out_tag     <= r_res.tag;
            o_out_valid   <= r_res_valid;
            o_entry_total <= r_count;
            o_status      <= r_res_status;
        end
    end

    assign o_valid = r_ovld;

endmodule

// File: design/binary_heap_priority_queue_core.sv
// Top level of the binary heap priority queue core.
// Joins bhpq_ctrl and bhpq_dp; uses bhpq_pkg.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   input    | i_valid / o_stall   | i_kind, i_in_key, i_in_tag
//   result   | o_valid / i_stall   | o_out_key, o_out_tag, o_out_valid,
//            |                     | o_entry_total, o_status
//   config   | i_cfg_we            | i_cfg_wdata
//
// One beat in, one beat out. A peek reads the root and returns it; a rejected or unused
// kind goes straight to the result register. A push climbs from the new last slot and a
// pop sinks the last entry down from the root, level by level, and each places the entry
// where it stops. Each level is one registered read of the heap memory and one
// compare-and-write, over at most ten levels. Reset is synchronous, active low, and
// empties the heap at once.
// A held result does not block the next input beat; the controller waits only when a
// second result is ready before the first is taken.
module binary_heap_priority_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_kind,
    input  logic signed [bhpq_pkg::KEY_W-1:0] i_in_key,
    input  logic [bhpq_pkg::TAG_W-1:0]        i_in_tag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [bhpq_pkg::KEY_W-1:0] o_out_key,
    output logic [bhpq_pkg::TAG_W-1:0]        o_out_tag,
    output logic                              o_out_valid,
    output logic [bhpq_pkg::CNT_W-1:0]        o_entry_total,
    output logic [1:0]                        o_status
);
    import bhpq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bhpq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_key      (i_in_key),
        .i_in_tag      (i_in_tag),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_key     (o_out_key),
        .o_out_tag     (o_out_tag),
        .o_out_valid   (o_out_valid),
        .o_entry_total (o_entry_total),
        .o_status      (o_status)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_valid && i_stall))
        else $error("result register loaded while a beat is still held");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("controller did not leave idle after an accepted beat");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_valid)
        else $error("loaded result not presented");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> (o_status == ST_OK && o_entry_total <= CNT_W'(CAPACITY)))
        else $error("entry result with bad status or count");

endmodule
